// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the bit set block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/bsrf_pkg.sv
// Package with constants, action codes and helpers for the bit set block.
package bsrf_pkg;

    localparam int WORDS_DEFAULT = 32;
    localparam int WORD_BITS     = 32;

    typedef enum logic [2:0] {
        ACT_CLEAR = 3'd0,
        ACT_ADD   = 3'd1,
        ACT_RANGE = 3'd2,
        ACT_HIGH  = 3'd3,
        ACT_LIST  = 3'd4
    } t_action;

    // Position of the highest set bit; zero for an empty word.
    function automatic logic [4:0] top_bit(input logic [31:0] w);
        logic [4:0] b;
        b = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (w[i]) begin
                b = 5'(i);
            end
        end
        return b;
    endfunction

endpackage

// File: rtl/bitset_range_fill_find_highest.sv
// Bit set held in a word memory with clear, add, range fill, highest and list actions.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------
//  in      | input     | i_in_valid / o_in_stall   | action, first/end member, word
//  out     | output    | o_out_valid / i_out_stall | member, found, error, last
//
// One item is worked on at a time; the memory port walks one word per cycle.
// Clear writes every word; add and range fill read and write back each word touched;
// highest scans down from the top word to the first set one; listing emits one item
// per member (a single not-found item for an empty word); a rejected or empty request
// goes straight to its reply. After reset every word is cleared with the input stalled.
// A held result in the output register stalls only the cycle that must emit next.
`include "assert_macros.svh"

module bitset_range_fill_find_highest #(
    parameter int WORDS = bsrf_pkg::WORDS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [9:0]  i_first_member,
    input  logic [10:0] i_end_member,
    input  logic [4:0]  i_word_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_member,
    output logic        o_found,
    output logic        o_error,
    output logic        o_last
);

    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [16:0] CAP = 17'(WORDS * bsrf_pkg::WORD_BITS);
    localparam logic [16:0] WORDS17 = 17'(WORDS);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RANGE = 7'b0000100,
        S_HIGH  = 7'b0001000,
        S_LLOAD = 7'b0010000,
        S_LIST  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    function automatic logic [AW-1:0] to_addr(input logic [4:0] v);
        logic [15:0] t;
        t = 16'(v);
        return t[AW-1:0];
    endfunction

    logic [31:0] r_mem [WORDS];
    logic [31:0] r_rdata;

    t_state      r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_paddr, n_paddr;
    logic        r_pend, n_pend;
    logic        r_iss, n_iss;
    logic        r_clr_reply, n_clr_reply;
    logic [9:0]  r_s, n_s;
    logic [10:0] r_e, n_e;
    logic [4:0]  r_wi, n_wi;
    logic [31:0] r_word, n_word;
    logic [9:0]  r_res_member, n_res_member;
    logic        r_res_found, n_res_found;
    logic        r_res_error, n_res_error;
    logic        r_ov;
    logic [9:0]  r_om;
    logic        r_of, r_oe, r_ol;

    logic          rd_en, we;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   wr_data;
    logic          emit, e_found, e_error, e_last;
    logic [9:0]    e_member;
    logic          can_emit, accept;

    logic [AW-1:0] sw, ew;
    logic [10:0]   em1;
    logic [31:0]   mask;
    logic [4:0]    top_r, top_w;
    logic [31:0]   word_cl;
    logic [15:0]   pwide;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign can_emit = !r_ov || !i_out_stall;

    assign em1   = r_e - 11'd1;
    assign sw    = to_addr(r_s[9:5]);
    assign ew    = to_addr(em1[9:5]);
    assign top_r = bsrf_pkg::top_bit(r_rdata);
    assign top_w = bsrf_pkg::top_bit(r_word);
    assign pwide = 16'(r_paddr);
    assign word_cl = r_word & ~(32'd1 << top_w);

    always_comb begin
        mask = '1;
        if (r_paddr == sw) begin
            mask = mask & ('1 << r_s[4:0]);
        end
        if (r_paddr == ew) begin
            mask = mask & ('1 >> (5'd31 - em1[4:0]));
        end
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_paddr      = r_paddr;
        n_pend       = r_pend;
        n_iss        = r_iss;
        n_clr_reply  = r_clr_reply;
        n_s          = r_s;
        n_e          = r_e;
        n_wi         = r_wi;
        n_word       = r_word;
        n_res_member = r_res_member;
        n_res_found  = r_res_found;
        n_res_error  = r_res_error;
        rd_en        = 1'b0;
        rd_addr      = r_addr;
        we           = 1'b0;
        wr_addr      = r_addr;
        wr_data      = '0;
        emit         = 1'b0;
        e_member     = '0;
        e_found      = 1'b0;
        e_error      = 1'b0;
        e_last       = 1'b1;

        case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                if (r_addr == AW'(WORDS - 1)) begin
                    n_res_member = '0;
                    n_res_found  = 1'b0;
                    n_res_error  = 1'b0;
                    n_state      = r_clr_reply ? S_DONE : S_IDLE;
                    n_clr_reply  = 1'b0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_res_member = '0;
                    n_res_found  = 1'b0;
                    n_res_error  = 1'b0;
                    n_iss        = 1'b0;
                    n_pend       = 1'b0;
                    n_state      = S_DONE;
                    case (bsrf_pkg::t_action'(i_action))
                        bsrf_pkg::ACT_CLEAR: begin
                            n_addr      = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_CLEAR;
                        end
                        bsrf_pkg::ACT_ADD: begin
                            if (17'(i_first_member) >= CAP) begin
                                n_res_error = 1'b1;
                            end else begin
                                n_s     = i_first_member;
                                n_e     = 11'(i_first_member) + 11'd1;
                                n_addr  = to_addr(i_first_member[9:5]);
                                n_state = S_RANGE;
                            end
                        end
                        bsrf_pkg::ACT_RANGE: begin
                            if (11'(i_first_member) > i_end_member
                                    || 17'(i_end_member) > CAP) begin
                                n_res_error = 1'b1;
                            end else if (11'(i_first_member) != i_end_member) begin
                                n_s     = i_first_member;
                                n_e     = i_end_member;
                                n_addr  = to_addr(i_first_member[9:5]);
                                n_state = S_RANGE;
                            end
                        end
                        bsrf_pkg::ACT_HIGH: begin
                            n_addr  = AW'(WORDS - 1);
                            n_state = S_HIGH;
                        end
                        bsrf_pkg::ACT_LIST: begin
                            if (17'(i_word_index) >= WORDS17) begin
                                n_res_error = 1'b1;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = to_addr(i_word_index);
                                n_wi    = i_word_index;
                                n_state = S_LLOAD;
                            end
                        end
                        default: begin
                            n_res_error = 1'b1;
                        end
                    endcase
                end
            end
            S_RANGE: begin
                we      = r_pend;
                wr_addr = r_paddr;
                wr_data = r_rdata | mask;
                rd_en   = !r_iss;
                n_pend  = !r_iss;
                n_paddr = r_addr;
                if (!r_iss) begin
                    if (r_addr == ew) begin
                        n_iss = 1'b1;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end else if (!r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_HIGH: begin
                rd_en   = !r_iss;
                n_pend  = !r_iss;
                n_paddr = r_addr;
                if (!r_iss) begin
                    if (r_addr == '0) begin
                        n_iss = 1'b1;
                    end else begin
                        n_addr = r_addr - AW'(1);
                    end
                end
                if (r_pend && (r_rdata != '0)) begin
                    n_res_member = {pwide[4:0], top_r};
                    n_res_found  = 1'b1;
                    n_state      = S_DONE;
                end else if (r_pend && (r_paddr == '0)) begin
                    n_state = S_DONE;
                end
            end
            S_LLOAD: begin
                n_word  = r_rdata;
                n_state = (r_rdata == '0) ? S_DONE : S_LIST;
            end
            S_LIST: begin
                if (can_emit) begin
                    emit     = 1'b1;
                    e_member = {r_wi, top_w};
                    e_found  = 1'b1;
                    e_last   = (word_cl == '0);
                    n_word   = word_cl;
                    if (word_cl == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DONE: begin
                if (can_emit) begin
                    emit     = 1'b1;
                    e_member = r_res_member;
                    e_found  = r_res_found;
                    e_error  = r_res_error;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_iss       <= 1'b0;
            r_clr_reply <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_iss       <= n_iss;
            r_clr_reply <= n_clr_reply;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_paddr      <= n_paddr;
        r_s          <= n_s;
        r_e          <= n_e;
        r_wi         <= n_wi;
        r_word       <= n_word;
        r_res_member <= n_res_member;
        r_res_found  <= n_res_found;
        r_res_error  <= n_res_error;
        if (emit) begin
            r_om <= e_member;
            r_of <= e_found;
            r_oe <= e_error;
            r_ol <= e_last;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_member    = r_om;
    assign o_found     = r_of;
    assign o_error     = r_oe;
    assign o_last      = r_ol;

    `ASSERT_SAME(a_rmw_no_overlap, i_clk, i_rst_n, we && rd_en, rd_addr != wr_addr, "read and write hit the same word")
    `ASSERT_SAME(a_write_states, i_clk, i_rst_n, we, (r_state == S_CLEAR) || (r_state == S_RANGE), "memory written outside clear or fill")
    `ASSERT_NEXT(a_list_end, i_clk, i_rst_n, (r_state == S_LIST) && emit && e_last, r_state == S_IDLE, "listing did not end after last item")
    `ASSERT_SAME(a_found_ok, i_clk, i_rst_n, o_out_valid && o_found, !o_error, "found item flagged as error")

endmodule
